>>> src/ndt_pkg.sv
`timescale 1ns / 1ps

package ndt_pkg;

   // Default table depth and the number of significant characters per name.
   localparam int unsigned CAPACITY_DEF = 1024;
   localparam int unsigned NAME_CHARS   = 8;

   localparam int unsigned NAME_W  = 64;
   localparam int unsigned OP_W    = 3;
   localparam int unsigned RIDX_W  = 10;
   localparam int unsigned RCNT_W  = 11;

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR  = 3'd0,
      OP_INSERT = 3'd1,
      OP_LOOKUP = 3'd2,
      OP_READ   = 3'd3,
      OP_APPEND = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_READ,
      ST_EMIT
   } state_type;

   // Clears every byte from the first NUL on, and every byte past NAME_CHARS.
   function automatic logic [NAME_W-1:0] normalize_name(input logic [NAME_W-1:0] key);
      logic [NAME_W-1:0] res;
      logic              ended;
      res   = '0;
      ended = 1'b0;
      for (int i = 0; i < 8; i++) begin
         if (key[8*i +: 8] == 8'h00 || i >= int'(NAME_CHARS)) begin
            ended = 1'b1;
         end
         if (!ended) begin
            res[8*i +: 8] = key[8*i +: 8];
         end
      end
      return res;
   endfunction

   // Maps ASCII upper case letters onto lower case; all other bytes pass as they are.
   function automatic logic [NAME_W-1:0] fold_name(input logic [NAME_W-1:0] name);
      logic [NAME_W-1:0] res;
      for (int i = 0; i < 8; i++) begin
         if (name[8*i +: 8] >= 8'h41 && name[8*i +: 8] <= 8'h5A) begin
            res[8*i +: 8] = name[8*i +: 8] + 8'h20;
         end else begin
            res[8*i +: 8] = name[8*i +: 8];
         end
      end
      return res;
   endfunction

endpackage

>>> src/name_dedup_table_top.sv
`timescale 1ns / 1ps
// Clear, append, unused codes and a read past the count go from idle straight to emit; a read
// passes through the read state. Insert and lookup scan the table one entry per cycle through
// the memory read port, stopping at the first hit or after every entry below the count.
// Throughput: one item at a time; the next item is taken once the result is registered.
// Reset (synchronous, active high) empties the table and drops any pending result.
// The name memory needs no clearing pass; only entries below the count are ever read.
module name_dedup_table_top #(
   parameter int unsigned CAPACITY = ndt_pkg::CAPACITY_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [ndt_pkg::OP_W-1:0]   req_opcode,
   input  logic [ndt_pkg::NAME_W-1:0] req_name_key,
   input  logic [ndt_pkg::RIDX_W-1:0] req_entry_index,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [ndt_pkg::RIDX_W-1:0] rsp_result_index,
   output logic                       rsp_found,
   output logic                       rsp_table_full,
   output logic [ndt_pkg::NAME_W-1:0] rsp_name_out,
   output logic [ndt_pkg::RCNT_W-1:0] rsp_entry_count
);
   import ndt_pkg::*;

   localparam int unsigned IDXW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned CNTW = $clog2(CAPACITY + 1);
   // Width wide enough to compare a request index against the count.
   localparam int unsigned CMPW = ((CNTW > RIDX_W) ? CNTW : RIDX_W) + 1;

   // Control state.
   state_type         state_ff, state_in;
   logic [CNTW-1:0]   count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Working registers of the item in flight.
   op_type            op_ff, op_in;
   logic [NAME_W-1:0] key_ff, key_in;
   logic [CNTW-1:0]   iss_ff, iss_in;
   logic              pend_ff, pend_in;
   logic [IDXW-1:0]   cmp_ff, cmp_in;
   logic [IDXW-1:0]   res_index_ff, res_index_in;
   logic              res_found_ff, res_found_in;
   logic              res_full_ff, res_full_in;
   logic [NAME_W-1:0] res_name_ff, res_name_in;

   // Output register.
   logic [RIDX_W-1:0] rsp_index_ff;
   logic              rsp_found_ff;
   logic              rsp_full_ff;
   logic [NAME_W-1:0] rsp_name_ff;
   logic [RCNT_W-1:0] rsp_count_ff;
   logic              rsp_load;

   // Memory port controls.
   logic              rd_en;
   logic [IDXW-1:0]   rd_addr;
   logic              wr_en;
   logic [NAME_W-1:0] wr_data;
   logic [NAME_W-1:0] rd_data;
   logic              match;

   logic [NAME_W-1:0] req_key_norm;
   logic              out_free;
   logic              append_go;
   logic [NAME_W-1:0] append_key;

   assign req_key_norm = normalize_name(req_name_key);
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign req_ready    = (state_ff == ST_IDLE);

   ndt_store #(
      .CAPACITY (CAPACITY),
      .IDXW     (IDXW)
   ) u_store (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDXW-1:0]),
      .wr_data (wr_data),
      .key     (key_ff),
      .rd_data (rd_data),
      .match   (match)
   );

   // Next state and datapath control. Only one item is in flight, so a memory
   // write never overlaps a read of the same entry and no forwarding is needed.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      iss_in       = iss_ff;
      pend_in      = pend_ff;
      cmp_in       = cmp_ff;
      res_index_in = res_index_ff;
      res_found_in = res_found_ff;
      res_full_in  = res_full_ff;
      res_name_in  = res_name_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;
      append_go    = 1'b0;
      append_key   = key_ff;
      rsp_load     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in        = op_type'(req_opcode);
               key_in       = req_key_norm;
               res_index_in = '0;
               res_found_in = 1'b0;
               res_full_in  = 1'b0;
               res_name_in  = '0;
               case (op_type'(req_opcode))
                  OP_CLEAR: begin
                     count_in = '0;
                     state_in = ST_EMIT;
                  end
                  OP_INSERT, OP_LOOKUP: begin
                     iss_in   = '0;
                     pend_in  = 1'b0;
                     state_in = ST_SCAN;
                  end
                  OP_READ: begin
                     if (CMPW'(req_entry_index) < CMPW'(count_ff)) begin
                        rd_en        = 1'b1;
                        rd_addr      = IDXW'(req_entry_index);
                        res_found_in = 1'b1;
                        res_index_in = IDXW'(req_entry_index);
                        state_in     = ST_READ;
                     end else begin
                        state_in = ST_EMIT;
                     end
                  end
                  OP_APPEND: begin
                     append_go  = 1'b1;
                     append_key = req_key_norm;
                     state_in   = ST_EMIT;
                  end
                  default: begin
                     state_in = ST_EMIT;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (pend_ff && match) begin
               res_found_in = 1'b1;
               res_index_in = cmp_ff;
               pend_in      = 1'b0;
               state_in     = ST_EMIT;
            end else if (!pend_ff && iss_ff == count_ff) begin
               append_go = (op_ff == OP_INSERT);
               state_in  = ST_EMIT;
            end else if (iss_ff < count_ff) begin
               rd_en   = 1'b1;
               rd_addr = iss_ff[IDXW-1:0];
               pend_in = 1'b1;
               cmp_in  = iss_ff[IDXW-1:0];
               iss_in  = iss_ff + 1'b1;
            end else begin
               pend_in = 1'b0;
            end
         end
         ST_READ: begin
            res_name_in = rd_data;
            state_in    = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Append the key at the end of the table, or flag the table as full.
      wr_en   = 1'b0;
      wr_data = append_key;
      if (append_go) begin
         if (count_ff >= CNTW'(CAPACITY)) begin
            res_full_in = 1'b1;
         end else begin
            wr_en        = 1'b1;
            res_index_in = count_ff[IDXW-1:0];
            count_in     = count_ff + 1'b1;
         end
      end

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      key_ff       <= key_in;
      iss_ff       <= iss_in;
      cmp_ff       <= cmp_in;
      res_index_ff <= res_index_in;
      res_found_ff <= res_found_in;
      res_full_ff  <= res_full_in;
      res_name_ff  <= res_name_in;
      if (rsp_load) begin
         rsp_index_ff <= RIDX_W'(res_index_ff);
         rsp_found_ff <= res_found_ff;
         rsp_full_ff  <= res_full_ff;
         rsp_name_ff  <= res_name_ff;
         rsp_count_ff <= RCNT_W'(count_ff);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_index = rsp_index_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_table_full   = rsp_full_ff;
   assign rsp_name_out     = rsp_name_ff;
   assign rsp_entry_count  = rsp_count_ff;

endmodule

>>> src/ndt_store.sv
`timescale 1ns / 1ps

module ndt_store #(
   parameter int unsigned CAPACITY = ndt_pkg::CAPACITY_DEF,
   parameter int unsigned IDXW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
   input  logic                       clock,
   input  logic                       rd_en,
   input  logic [IDXW-1:0]            rd_addr,
   input  logic                       wr_en,
   input  logic [IDXW-1:0]            wr_addr,
   input  logic [ndt_pkg::NAME_W-1:0] wr_data,
   input  logic [ndt_pkg::NAME_W-1:0] key,
   output logic [ndt_pkg::NAME_W-1:0] rd_data,
   output logic                       match
);
   import ndt_pkg::*;

   logic [NAME_W-1:0] mem [CAPACITY];
   logic [NAME_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Case-insensitive compare of the last word read against the key.
   assign rd_data = rd_data_ff;
   assign match   = (fold_name(rd_data_ff) == fold_name(key));

endmodule

>>> src/ndt_checker.sv
`timescale 1ns / 1ps

module ndt_checker #(
   parameter int unsigned CAPACITY = ndt_pkg::CAPACITY_DEF
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [ndt_pkg::RIDX_W-1:0] rsp_result_index,
   input logic                       rsp_found,
   input logic                       rsp_table_full,
   input logic [ndt_pkg::NAME_W-1:0] rsp_name_out,
   input logic [ndt_pkg::RCNT_W-1:0] rsp_entry_count
);
   import ndt_pkg::*;

   // A refused store never reports a match or an index.
   a_full_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_table_full |-> !rsp_found && rsp_result_index == '0)
      else $error("table_full result carries found or an index");

   // A name is returned only with a valid read.
   a_name_needs_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_name_out == '0)
      else $error("name_out is nonzero without found");

   // The count never passes the table depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_entry_count) <= CAPACITY || CAPACITY > 2047)
      else $error("entry_count exceeds capacity");

   // One item at a time: after a request transfer the block is busy.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while an item is in flight");

   // Reset leaves no result pending.
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind name_dedup_table_top ndt_checker #(.CAPACITY(CAPACITY)) u_ndt_checker (.*);
